>>> rtl/core/id3fs_pkg.sv
`default_nettype none
package id3fs_pkg;

	localparam int WIN_LEN  = 8;
	localparam int HDR_LEN  = 10;
	localparam int QDEPTH   = 4;
	localparam int QAW      = $clog2(QDEPTH);
	localparam int LEN_W    = 28;

	localparam logic [1:0] KIND_HDR = 2'd0;
	localparam logic [1:0] KIND_VAL = 2'd1;
	localparam logic [1:0] KIND_END = 2'd2;

	// flag bytes skipped after the eight header bytes seen in the window
	localparam logic [1:0] FLAG_BYTES = 2'(HDR_LEN - WIN_LEN);

	typedef struct packed {
		logic [1:0]       kind;
		logic [31:0]      id;
		logic [LEN_W-1:0] len;
		logic [7:0]       val;
		logic             done;
		logic             trunc;
	} res_t;

	// all results caused by one input word: an optional header/value result,
	// then an optional end item
	typedef struct packed {
		logic has_main;
		res_t main;
		logic has_end;
		logic cut;
	} entry_t;

	function automatic logic is_id_char(input logic [7:0] c);
		return (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h30 && c <= 8'h39);
	endfunction

endpackage
`default_nettype wire

>>> rtl/core/id3fs_byte_if.sv
`default_nettype none
interface id3fs_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] tag_byte;
	logic       end_of_tag;

	modport source(output valid, tag_byte, end_of_tag, input ready);
	modport sink(input valid, tag_byte, end_of_tag, output ready);
endinterface
`default_nettype wire

>>> rtl/core/id3fs_item_if.sv
`default_nettype none
interface id3fs_item_if;
	logic        valid;
	logic        ready;
	logic [1:0]  item_kind;
	logic [31:0] frame_id;
	logic [27:0] frame_length;
	logic [7:0]  value_byte;
	logic        frame_done;
	logic        truncated;
	logic        run_last;

	modport source(output valid, item_kind, frame_id, frame_length, value_byte,
		frame_done, truncated, run_last, input ready);
	modport sink(input valid, item_kind, frame_id, frame_length, value_byte,
		frame_done, truncated, run_last, output ready);
endinterface
`default_nettype wire

>>> rtl/core/id3fs_front.sv
`default_nettype none
module id3fs_front (
	input  wire logic             clk,
	input  wire logic             arst_n,
	id3fs_byte_if.sink            tag_bytes,
	output logic                  push_valid,
	input  wire logic             push_ready,
	output id3fs_pkg::entry_t     push_entry
);
	import id3fs_pkg::*;

	logic [7:0]       win_q [WIN_LEN-1];
	logic [2:0]       fill_q;
	logic [1:0]       hdr_left_q;
	logic [LEN_W-1:0] pay_left_q;

	logic             accept;
	logic [7:0]       tb;
	logic             match;
	logic [LEN_W-1:0] hdr_len;
	logic [LEN_W-1:0] pay_after;
	logic             win_write;
	logic             win_slide;
	logic             got_match;
	res_t             main_res;
	logic             has_main;

	assign tb              = tag_bytes.tag_byte;
	assign tag_bytes.ready = push_ready;
	assign accept          = tag_bytes.valid && push_ready;

	// window holds the seven oldest bytes; the new byte completes it
	always_comb begin
		match = (tb < 8'h80);
		for (int i = 0; i < 4; i++) begin
			match = match && is_id_char(win_q[i]);
		end
		for (int i = 4; i < WIN_LEN-1; i++) begin
			match = match && (win_q[i] < 8'h80);
		end
	end

	assign hdr_len = {win_q[4][6:0], win_q[5][6:0], win_q[6][6:0], tb[6:0]};

	always_comb begin
		main_res  = '0;
		has_main  = 1'b0;
		pay_after = pay_left_q;
		win_write = 1'b0;
		win_slide = 1'b0;
		got_match = 1'b0;
		if (hdr_left_q != 2'd0) begin
			pay_after = pay_left_q;
		end else if (pay_left_q != '0) begin
			pay_after     = pay_left_q - 1'b1;
			has_main      = 1'b1;
			main_res.kind = KIND_VAL;
			main_res.val  = tb;
			main_res.done = (pay_left_q == LEN_W'(1));
		end else if (fill_q == 3'(WIN_LEN-1)) begin
			if (match) begin
				got_match     = 1'b1;
				has_main      = 1'b1;
				pay_after     = hdr_len;
				main_res.kind = KIND_HDR;
				main_res.id   = {win_q[0], win_q[1], win_q[2], win_q[3]};
				main_res.len  = hdr_len;
				main_res.done = (hdr_len == '0);
			end else begin
				win_slide = 1'b1;
			end
		end else begin
			win_write = 1'b1;
		end
	end

	always_comb begin
		push_entry.has_main = has_main;
		push_entry.main     = main_res;
		push_entry.has_end  = tag_bytes.end_of_tag;
		push_entry.cut      = (pay_after != '0);
		push_valid          = tag_bytes.valid && (has_main || tag_bytes.end_of_tag);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < WIN_LEN-1; i++) begin
				win_q[i] <= '0;
			end
			fill_q     <= '0;
			hdr_left_q <= '0;
			pay_left_q <= '0;
		end else if (accept) begin
			if (tag_bytes.end_of_tag) begin
				for (int i = 0; i < WIN_LEN-1; i++) begin
					win_q[i] <= '0;
				end
				fill_q     <= '0;
				hdr_left_q <= '0;
				pay_left_q <= '0;
			end else begin
				pay_left_q <= pay_after;
				if (hdr_left_q != 2'd0) begin
					hdr_left_q <= hdr_left_q - 1'b1;
				end
				if (got_match) begin
					hdr_left_q <= FLAG_BYTES;
					fill_q     <= '0;
				end
				if (win_write) begin
					win_q[fill_q] <= tb;
					fill_q        <= fill_q + 1'b1;
				end
				if (win_slide) begin
					for (int i = 0; i < WIN_LEN-2; i++) begin
						win_q[i] <= win_q[i+1];
					end
					win_q[WIN_LEN-2] <= tb;
				end
			end
		end
	end

endmodule
`default_nettype wire

>>> rtl/core/id3fs_queue.sv
`default_nettype none
module id3fs_queue (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                push_valid,
	output logic                     push_ready,
	input  wire id3fs_pkg::entry_t   push_entry,
	output logic                     head_valid,
	input  wire logic                pop,
	output id3fs_pkg::entry_t        head_entry
);
	import id3fs_pkg::*;

	entry_t       mem_q [QDEPTH];
	logic [QAW-1:0] wr_ptr_q;
	logic [QAW-1:0] rd_ptr_q;
	logic [QAW:0]   count_q;
	logic           do_push;
	logic           do_pop;

	assign push_ready = (count_q != (QAW+1)'(QDEPTH));
	assign head_valid = (count_q != '0);
	assign head_entry = mem_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop && head_valid;

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			unique case ({do_push, do_pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule
`default_nettype wire

>>> rtl/core/id3fs_back.sv
`default_nettype none
module id3fs_back (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               head_valid,
	input  wire id3fs_pkg::entry_t  head_entry,
	output logic                    pop,
	id3fs_item_if.source            items
);
	import id3fs_pkg::*;

	logic main_sent_q;
	logic out_valid_q;
	res_t out_res_q;
	logic out_last_q;

	res_t next_res;
	logic next_last;
	logic load;

	// end item goes after the main result of the same word
	always_comb begin
		next_res = '0;
		if (head_entry.has_main && !main_sent_q) begin
			next_res  = head_entry.main;
			next_last = !head_entry.has_end;
		end else begin
			next_res.kind  = KIND_END;
			next_res.done  = head_entry.cut;
			next_res.trunc = head_entry.cut;
			next_last      = 1'b1;
		end
	end

	assign load = head_valid && (!out_valid_q || items.ready);
	assign pop  = load && next_last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			main_sent_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (load) begin
				main_sent_q <= !next_last;
				out_valid_q <= 1'b1;
			end else if (items.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_res_q  <= next_res;
			out_last_q <= next_last;
		end
	end

	assign items.valid        = out_valid_q;
	assign items.item_kind    = out_res_q.kind;
	assign items.frame_id     = out_res_q.id;
	assign items.frame_length = out_res_q.len;
	assign items.value_byte   = out_res_q.val;
	assign items.frame_done   = out_res_q.done;
	assign items.truncated    = out_res_q.trunc;
	assign items.run_last     = out_last_q;

endmodule
`default_nettype wire

>>> rtl/core/id3_frame_scanner.sv
// ID3v2 frame scanner.
// tag_bytes: one tag byte per word, end_of_tag set on the final byte.
// items: header items (id, syncsafe length), value items (one payload byte,
//   frame_done on the last), and one end item after the final byte, with
//   truncated/frame_done set if payload bytes were still due. run_last marks
//   the last item caused by an input word.
// Throughput: one byte per cycle while the queue has room. The final byte
//   of a tag can cause two items, which leave the output one after the other.
// The edge that accepts a byte writes its entry into the four-entry queue;
//   the output register loads the item from the queue once it is free.
// Bytes that are only buffered or skipped cause no item.
// Reset clears the window, counters, queue and output register.
// When the receiver stalls, the output register holds and the queue fills;
//   tag_bytes.ready drops once four words wait in the queue.
`default_nettype none
module id3_frame_scanner (
	input  wire logic     clk,
	input  wire logic     arst_n,
	id3fs_byte_if.sink    tag_bytes,
	id3fs_item_if.source  items
);
	import id3fs_pkg::*;

	logic   push_valid;
	logic   push_ready;
	entry_t push_entry;
	logic   head_valid;
	logic   pop;
	entry_t head_entry;

	id3fs_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.tag_bytes  (tag_bytes),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_entry (push_entry)
	);

	id3fs_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_entry (push_entry),
		.head_valid (head_valid),
		.pop        (pop),
		.head_entry (head_entry)
	);

	id3fs_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head_entry (head_entry),
		.pop        (pop),
		.items      (items)
	);

endmodule
`default_nettype wire

>>> rtl/core/id3fs_checker.sv
`default_nettype none
module id3fs_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        out_valid,
	input wire logic        out_ready,
	input wire logic [1:0]  item_kind,
	input wire logic [31:0] frame_id,
	input wire logic [27:0] frame_length,
	input wire logic        frame_done,
	input wire logic        truncated,
	input wire logic        run_last
);
	import id3fs_pkg::*;

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("item word dropped while stalled");

	a_kind: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (item_kind == KIND_HDR || item_kind == KIND_VAL ||
			item_kind == KIND_END))
		else $error("bad item kind");

	a_trunc: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && truncated |-> item_kind == KIND_END && frame_done && run_last)
		else $error("truncation outside end item");

	a_empty: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && item_kind == KIND_HDR |-> frame_done == (frame_length == '0))
		else $error("empty-frame done flag wrong");

	a_end_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && item_kind == KIND_END |-> run_last && frame_id == '0 &&
			frame_length == '0)
		else $error("end item malformed");

endmodule

bind id3_frame_scanner id3fs_checker u_id3fs_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.out_valid    (items.valid),
	.out_ready    (items.ready),
	.item_kind    (items.item_kind),
	.frame_id     (items.frame_id),
	.frame_length (items.frame_length),
	.frame_done   (items.frame_done),
	.truncated    (items.truncated),
	.run_last     (items.run_last)
);
`default_nettype wire

>>> bench/tb_id3_frame_scanner.sv
`default_nettype none
module tb_id3_frame_scanner;
	import id3fs_pkg::*;

	localparam int STUCK_LIMIT    = 1000;
	localparam int RX_HOLD_CYCLES = 64;
	localparam int RANDOM_WORDS   = 300;
	localparam int CALM_AFTER     = 260;

	typedef struct packed {
		logic [1:0]  kind;
		logic [31:0] id;
		logic [27:0] len;
		logic [7:0]  val;
		logic        done;
		logic        trunc;
		logic        last;
	} scan_item_t;

	typedef struct {
		logic [7:0] b;
		bit         eot;
		bit         known;
		scan_item_t want;
	} stim_row_t;

	logic clk;
	logic arst_n;

	id3fs_byte_if tag_bytes();
	id3fs_item_if items();

	id3_frame_scanner u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.tag_bytes (tag_bytes),
		.items     (items)
	);

	// scanner state as the predictor sees it
	logic [7:0]  win [WIN_LEN];
	int          fill;
	int          hdr_left;
	logic [27:0] pay_left;

	scan_item_t  pending_items [$];
	stim_row_t   dir_rows [$];
	logic [7:0]  tag_q [$];

	int errors;
	int words_sent;
	int stuck;
	bit calm;
	bit rx_hold;

	initial clk = 1'b0;
	always #5 clk = ~clk;

	function automatic scan_item_t make_item(logic [1:0] kind, logic [31:0] id,
		logic [27:0] len, logic [7:0] val, logic done, logic trunc, logic last);
		scan_item_t r;
		r.kind = kind;
		r.id = id;
		r.len = len;
		r.val = val;
		r.done = done;
		r.trunc = trunc;
		r.last = last;
		return r;
	endfunction

	function automatic void clear_scan();
		foreach (win[i]) win[i] = 8'h00;
		fill = 0;
		hdr_left = 0;
		pay_left = '0;
	endfunction

	// advance the scanner by one tag byte, queue the items it causes
	function automatic int scan_byte(logic [7:0] b, bit eot);
		int n;
		bit ok;
		bit cut;
		logic [27:0] len;
		scan_item_t t;
		n = 0;
		if (hdr_left > 0) begin
			hdr_left--;
		end else if (pay_left != 0) begin
			pay_left--;
			pending_items.push_back(make_item(KIND_VAL, '0, '0, b, pay_left == 0, 1'b0, 1'b0));
			n++;
		end else begin
			win[fill] = b;
			fill++;
			if (fill == WIN_LEN) begin
				ok = 1'b1;
				for (int i = 0; i < 4; i++)
					if (!((win[i] >= "A" && win[i] <= "Z") || (win[i] >= "0" && win[i] <= "9")))
						ok = 1'b0;
				for (int i = 4; i < WIN_LEN; i++)
					if (win[i][7]) ok = 1'b0;
				if (ok) begin
					len = {win[4][6:0], win[5][6:0], win[6][6:0], win[7][6:0]};
					pending_items.push_back(make_item(KIND_HDR,
						{win[0], win[1], win[2], win[3]}, len, 8'h00, len == 0, 1'b0, 1'b0));
					n++;
					hdr_left = HDR_LEN - WIN_LEN;
					pay_left = len;
					fill = 0;
				end else begin
					for (int i = 0; i < WIN_LEN - 1; i++) win[i] = win[i+1];
					fill = WIN_LEN - 1;
				end
			end
		end
		if (eot) begin
			cut = pay_left != 0;
			pending_items.push_back(make_item(KIND_END, '0, '0, 8'h00, cut, cut, 1'b0));
			n++;
			clear_scan();
		end
		if (n > 0) begin
			t = pending_items.pop_back();
			t.last = 1'b1;
			pending_items.push_back(t);
		end
		return n;
	endfunction

	function automatic void add_row(logic [7:0] b, bit eot = 1'b0);
		stim_row_t r;
		r.b = b;
		r.eot = eot;
		r.known = 1'b0;
		r.want = '0;
		dir_rows.push_back(r);
	endfunction

	// want is the last item this word must cause
	function automatic void add_checked_row(logic [7:0] b, bit eot, scan_item_t want);
		stim_row_t r;
		r.b = b;
		r.eot = eot;
		r.known = 1'b1;
		r.want = want;
		dir_rows.push_back(r);
	endfunction

	function automatic logic [7:0] id_char();
		int pick;
		pick = $urandom_range(0, 15);
		if (pick == 0) begin
			// just outside the legal id ranges, or anything at all
			case ($urandom_range(0, 4))
				0: return "@";
				1: return "[";
				2: return "/";
				3: return ":";
				default: return 8'($urandom_range(0, 255));
			endcase
		end else if (pick < 7) begin
			return 8'($urandom_range(8'h30, 8'h39));
		end
		return 8'($urandom_range(8'h41, 8'h5A));
	endfunction

	task automatic put_byte(logic [7:0] b, bit eot, bit known, scan_item_t want);
		int n;
		if (!calm && $urandom_range(0, 4) == 0) begin
			tag_bytes.valid <= 1'b0;
			repeat ($urandom_range(1, 16)) @(posedge clk);
		end
		tag_bytes.valid <= 1'b1;
		tag_bytes.tag_byte <= b;
		tag_bytes.end_of_tag <= eot;
		@(posedge clk);
		while (!tag_bytes.ready) @(posedge clk);
		n = scan_byte(b, eot);
		if (known) begin
			if (n > 0) void'(pending_items.pop_back());
			pending_items.push_back(want);
		end
		words_sent++;
	endtask

	task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
		if (want !== got) begin
			errors++;
			$display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
		end
	endtask

	// tx side: directed table, then random tags
	initial begin : tx_side
		int tags;
		int plen;
		int keep;
		arst_n <= 1'b0;
		tag_bytes.valid <= 1'b0;
		tag_bytes.tag_byte <= 8'h00;
		tag_bytes.end_of_tag <= 1'b0;
		errors = 0;
		words_sent = 0;
		calm = 1'b0;
		rx_hold = 1'b0;
		clear_scan();

		// max-length header completing on the final byte: header, then cut end item
		add_row("[");
		add_row("Z"); add_row("Z"); add_row("9"); add_row("9");
		add_row(8'h7F); add_row(8'h7F); add_row(8'h7F);
		add_checked_row(8'h7F, 1'b1, make_item(KIND_END, '0, '0, 8'h00, 1'b1, 1'b1, 1'b1));
		// empty frame, flags consumed, end item without cut
		add_row("A"); add_row("0"); add_row("Z"); add_row("9");
		add_row(8'h00); add_row(8'h00); add_row(8'h00);
		add_checked_row(8'h00, 1'b0,
			make_item(KIND_HDR, 32'h41305A39, '0, 8'h00, 1'b1, 1'b0, 1'b1));
		add_row(8'hFF);
		add_checked_row(8'h80, 1'b1, make_item(KIND_END, '0, '0, 8'h00, 1'b0, 1'b0, 1'b1));
		// one-byte frame behind a bad lead byte, tag ends on the value byte
		add_row("@");
		add_row("B"); add_row("C"); add_row("D"); add_row("1");
		add_row(8'h00); add_row(8'h00); add_row(8'h00); add_row(8'h01);
		add_row(8'h00); add_row(8'h00);
		add_checked_row(8'hFF, 1'b1, make_item(KIND_END, '0, '0, 8'h00, 1'b0, 1'b0, 1'b1));

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_rows[i])
			put_byte(dir_rows[i].b, dir_rows[i].eot, dir_rows[i].known, dir_rows[i].want);

		tags = 0;
		while (words_sent < RANDOM_WORDS) begin
			tags++;
			if (tags == 6) rx_hold = 1'b1;
			if (tags == 12) begin
				tag_bytes.valid <= 1'b0;
				while (pending_items.size() != 0) @(posedge clk);
				@(posedge clk);
			end
			if (words_sent >= CALM_AFTER) calm = 1'b1;

			tag_q.delete();
			repeat ($urandom_range(0, 3)) tag_q.push_back(8'($urandom));
			repeat ($urandom_range(0, 3)) begin
				repeat (4) tag_q.push_back(id_char());
				if ($urandom_range(0, 9) == 0) begin
					// raw length bytes: may fail the header test or be huge
					repeat (4) tag_q.push_back(8'($urandom));
					plen = $urandom_range(0, 12);
				end else begin
					plen = $urandom_range(0, 6);
					tag_q.push_back(8'h00);
					tag_q.push_back(8'h00);
					tag_q.push_back(8'h00);
					tag_q.push_back(8'(plen));
				end
				repeat (2) tag_q.push_back(8'($urandom));
				repeat (plen) tag_q.push_back(8'($urandom));
			end
			repeat ($urandom_range(0, 3)) tag_q.push_back(8'($urandom));
			if (tag_q.size() == 0) tag_q.push_back(8'($urandom));
			if ($urandom_range(0, 5) == 0) begin
				keep = $urandom_range(1, tag_q.size());
				while (tag_q.size() > keep) void'(tag_q.pop_back());
			end
			foreach (tag_q[i])
				put_byte(tag_q[i], i == tag_q.size() - 1, 1'b0, '0);
		end

		tag_bytes.valid <= 1'b0;
		while (pending_items.size() != 0) @(posedge clk);
		repeat (12) @(posedge clk);
		if (errors == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

	// rx side: random stalls, one long hold on request
	initial begin : rx_side
		items.ready <= 1'b0;
		@(posedge clk);
		while (!arst_n) @(posedge clk);
		forever begin
			if (rx_hold) begin
				rx_hold = 1'b0;
				items.ready <= 1'b0;
				repeat (RX_HOLD_CYCLES) @(posedge clk);
			end else if (!calm && $urandom_range(0, 2) == 0) begin
				items.ready <= 1'b0;
				repeat ($urandom_range(1, 16)) @(posedge clk);
			end
			items.ready <= 1'b1;
			repeat ($urandom_range(1, 24)) @(posedge clk);
		end
	end

	always @(posedge clk) begin : item_check
		scan_item_t want;
		if (arst_n && items.valid && items.ready) begin
			if (pending_items.size() == 0) begin
				errors++;
				$display("%0t: unexpected item, expected none, actual kind %0h id %0h val %0h",
					$time, items.item_kind, items.frame_id, items.value_byte);
			end else begin
				want = pending_items.pop_front();
				check_field("item_kind", 32'(want.kind), 32'(items.item_kind));
				check_field("frame_id", want.id, items.frame_id);
				check_field("frame_length", 32'(want.len), 32'(items.frame_length));
				check_field("value_byte", 32'(want.val), 32'(items.value_byte));
				check_field("frame_done", 32'(want.done), 32'(items.frame_done));
				check_field("truncated", 32'(want.trunc), 32'(items.truncated));
				check_field("run_last", 32'(want.last), 32'(items.run_last));
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((tag_bytes.valid && tag_bytes.ready) || (items.valid && items.ready))
				stuck <= 0;
			else
				stuck <= stuck + 1;
			if (stuck == STUCK_LIMIT) begin
				$display("status: fail");
				$finish;
			end
		end else begin
			stuck <= 0;
		end
	end

endmodule
`default_nettype wire

>>> filelist.f
rtl/core/id3fs_pkg.sv
rtl/core/id3fs_byte_if.sv
rtl/core/id3fs_item_if.sv
rtl/core/id3fs_front.sv
rtl/core/id3fs_queue.sv
rtl/core/id3fs_back.sv
rtl/core/id3_frame_scanner.sv
rtl/core/id3fs_checker.sv
bench/tb_id3_frame_scanner.sv
